[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the timeout table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tte_pkg.sv]
// ----------------------------------------------------------------------------
// tte_pkg
// Shared sizes, codes and interface structs for the timeout table.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 16;
    localparam int ID_W        = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [CFG_W-1:0] PERIOD_RESET  = 16'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 1'b1;

    localparam logic STATUS_EXPIRED = 1'b0;
    localparam logic STATUS_REJECT  = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // compare unit results for one table entry
    typedef struct packed {
        logic id_eq;
        logic id_lt;
        logic expired;
    } match_t;

    typedef struct packed {
        logic                 en;
        logic                 id_en;
        logic [IDX_W-1:0]     addr;
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] stamp;
    } store_wr_t;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] stamp;
    } store_rd_t;

endpackage

`default_nettype wire

[sv/tte_slot_store.sv]
// ----------------------------------------------------------------------------
// tte_slot_store
// Id and time stamp memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_slot_store (
    input  wire logic                     aclk,
    input  wire tte_pkg::store_wr_t       wr,
    input  wire logic [tte_pkg::IDX_W-1:0] rd_addr,
    output tte_pkg::store_rd_t            rd_data
);
    import tte_pkg::*;

    logic [ID_W-1:0]      id_mem    [NUM_ENTRIES];
    logic [TIME_BITS-1:0] stamp_mem [NUM_ENTRIES];
    store_rd_t            rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            stamp_mem[wr.addr] <= wr.stamp;
            if (wr.id_en) begin
                id_mem[wr.addr] <= wr.id;
            end
        end
        rd_reg.id    <= id_mem[rd_addr];
        rd_reg.stamp <= stamp_mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

[sv/tte_match_unit.sv]
// ----------------------------------------------------------------------------
// tte_match_unit
// Shared compare unit: id equality, signed id order and age check.
// ----------------------------------------------------------------------------
`default_nettype none

module tte_match_unit (
    input  wire tte_pkg::store_rd_t              entry,
    input  wire logic [tte_pkg::ID_W-1:0]        ref_id,
    input  wire logic [tte_pkg::TIME_BITS-1:0]   now,
    input  wire logic [tte_pkg::CFG_W-1:0]       timeout,
    output tte_pkg::match_t                      match
);
    import tte_pkg::*;

    logic [TIME_BITS-1:0] age;

    // age wraps with the tick counter
    assign age           = now - entry.stamp;
    assign match.expired = (age >= TIME_BITS'(timeout));
    assign match.id_eq   = (entry.id == ref_id);
    assign match.id_lt   = ($signed(entry.id) < $signed(ref_id));

endmodule

`default_nettype wire

[sv/timeout_table_expiry_core.sv]
// ----------------------------------------------------------------------------
// timeout_table_expiry_core
// Pending-id table with tick-driven expiry scans and full-table rejects.
// ----------------------------------------------------------------------------
//
//   channel   dir   tdata            tuser          tlast
//   s_*       in    id [31:0]        operation[1:0] -
//   m_*       out   entry_id [31:0]  status [0]     last result of the item
//   cfg_*     in    cfg_wdata: register value, cfg_index 0 timeout, 1 period
//
// A tick that does not fire the scan leaves the block idle. Put and remove
// each sweep the slot memory once. A firing tick runs one sweep per expired
// entry (plus one sweep when nothing expired), each followed by an emit
// state; the single read port of the slot memory sets this pace.
// Reset clears the valid bits at once; no clearing pass is needed.
// A held result stalls the next emit only; s_tready is high while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module timeout_table_expiry_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input beats
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // [31:0] id
    input  wire logic [1:0]                    s_tuser,   // [1:0] operation
    // result beats
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] entry_id
    output logic [0:0]                         m_tuser,   // [0] status
    output logic                               m_tlast,
    // register writes
    input  wire logic                          cfg_wr_en,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tte_pkg::CFG_W-1:0]     cfg_wdata
);
    import tte_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    // control state
    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     timeout_reg, timeout_next;
    logic [CFG_W-1:0]     period_cfg_reg, period_cfg_next;
    logic [NUM_ENTRIES-1:0] slot_valid_reg, slot_valid_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CFG_W-1:0]     period_reg, period_next;
    logic                 armed_reg, armed_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic                 ev_vld_reg, ev_vld_next;
    logic                 hit_found_reg, hit_found_next;
    logic                 best_found_reg, best_found_next;
    logic [1:0]           cand_reg, cand_next;
    logic [EMIT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    op_t                  op_reg, op_next;
    logic [ID_W-1:0]      req_id_reg, req_id_next;
    logic [IDX_W-1:0]     ev_idx_reg, ev_idx_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [ID_W-1:0]      best_id_reg, best_id_next;
    logic                 pend_status_reg, pend_status_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 out_status_reg, out_status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    // datapath
    store_wr_t            wr;
    store_rd_t            rd_data;
    logic [IDX_W-1:0]     rd_addr;
    logic [ID_W-1:0]      ref_id;
    match_t               match;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic                 s_accept;
    logic                 out_free;
    logic                 sweep_done;
    logic [CFG_W-1:0]     period_inc;

    tte_slot_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tte_match_unit u_match (
        .entry   (rd_data),
        .ref_id  (ref_id),
        .now     (now_reg),
        .timeout (timeout_reg),
        .match   (match)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign sweep_done = (iss_reg == CNT_W'(NUM_ENTRIES)) && !ev_vld_reg;
    assign rd_addr    = iss_reg[IDX_W-1:0];
    assign period_inc = period_reg + CFG_W'(1);
    // scans order ids against the running minimum; put/remove match the request
    assign ref_id     = (op_reg == OP_TICK) ? best_id_reg : req_id_reg;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        timeout_next     = timeout_reg;
        period_cfg_next  = period_cfg_reg;
        slot_valid_next  = slot_valid_reg;
        now_next         = now_reg;
        period_next      = period_reg;
        armed_next       = armed_reg;
        iss_next         = iss_reg;
        ev_vld_next      = 1'b0;
        hit_found_next   = hit_found_reg;
        best_found_next  = best_found_reg;
        cand_next        = cand_reg;
        emit_cnt_next    = emit_cnt_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        op_next          = op_reg;
        req_id_next      = req_id_reg;
        ev_idx_next      = ev_idx_reg;
        hit_idx_next     = hit_idx_reg;
        best_idx_next    = best_idx_reg;
        best_id_next     = best_id_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        pend_last_next   = pend_last_reg;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        out_last_next    = out_last_reg;
        wr               = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_TIMEOUT: timeout_next    = cfg_wdata;
                REG_PERIOD:  period_cfg_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (op_t'(s_tuser))
                        OP_PUT, OP_REMOVE: begin
                            op_next        = op_t'(s_tuser);
                            req_id_next    = s_tdata;
                            iss_next       = '0;
                            hit_found_next = 1'b0;
                            state_next     = ST_SWEEP;
                        end
                        OP_TICK: begin
                            op_next  = OP_TICK;
                            now_next = now_reg + TIME_BITS'(1);
                            if (armed_reg) begin
                                // a zero period fires on every tick
                                if (period_inc >= period_cfg_reg) begin
                                    period_next     = '0;
                                    emit_cnt_next   = '0;
                                    best_found_next = 1'b0;
                                    cand_next       = '0;
                                    iss_next        = '0;
                                    state_next      = ST_SWEEP;
                                end else begin
                                    period_next = period_inc;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SWEEP: begin
                // issue one read per cycle, evaluate it in the next cycle
                if (iss_reg < CNT_W'(NUM_ENTRIES)) begin
                    iss_next    = iss_reg + CNT_W'(1);
                    ev_vld_next = 1'b1;
                    ev_idx_next = iss_reg[IDX_W-1:0];
                end

                if (ev_vld_reg && slot_valid_reg[ev_idx_reg]) begin
                    case (op_reg)
                        OP_PUT: begin
                            if (match.id_eq) begin
                                hit_found_next = 1'b1;
                                hit_idx_next   = ev_idx_reg;
                            end
                        end
                        OP_REMOVE: begin
                            if (match.id_eq) begin
                                slot_valid_next[ev_idx_reg] = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            if (match.expired) begin
                                if (cand_reg != 2'd2) begin
                                    cand_next = cand_reg + 2'd1;
                                end
                                if (!best_found_reg || match.id_lt) begin
                                    best_found_next = 1'b1;
                                    best_idx_next   = ev_idx_reg;
                                    best_id_next    = rd_data.id;
                                end
                            end
                        end
                        default: ;
                    endcase
                end

                if (sweep_done) begin
                    case (op_reg)
                        OP_PUT: begin
                            if (hit_found_reg) begin
                                wr.en      = 1'b1;
                                wr.addr    = hit_idx_reg;
                                wr.stamp   = now_reg;
                                state_next = ST_IDLE;
                            end else if (free_found) begin
                                wr.en    = 1'b1;
                                wr.id_en = 1'b1;
                                wr.addr  = free_idx;
                                wr.id    = req_id_reg;
                                wr.stamp = now_reg;
                                slot_valid_next[free_idx] = 1'b1;
                                // first entry restarts the check timer
                                if (slot_valid_reg == '0) begin
                                    armed_next  = 1'b1;
                                    period_next = '0;
                                end
                                state_next = ST_IDLE;
                            end else begin
                                pend_status_next = STATUS_REJECT;
                                pend_id_next     = req_id_reg;
                                pend_last_next   = 1'b1;
                                state_next       = ST_EMIT;
                            end
                        end
                        OP_TICK: begin
                            if (best_found_reg) begin
                                slot_valid_next[best_idx_reg] = 1'b0;
                                pend_status_next = STATUS_EXPIRED;
                                pend_id_next     = best_id_reg;
                                pend_last_next   = (cand_reg == 2'd1) ||
                                    (emit_cnt_reg == EMIT_W'(MAX_RESULTS - 1));
                                emit_cnt_next    = emit_cnt_reg + EMIT_W'(1);
                                state_next       = ST_EMIT;
                            end else begin
                                armed_next = |slot_valid_reg;
                                state_next = ST_IDLE;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_id_next     = pend_id_reg;
                    out_last_next   = pend_last_reg;
                    if (pend_last_reg) begin
                        if (op_reg == OP_TICK) begin
                            armed_next = |slot_valid_reg;
                        end
                        state_next = ST_IDLE;
                    end else begin
                        // next pass for the following smallest expired id
                        iss_next        = '0;
                        best_found_next = 1'b0;
                        cand_next       = '0;
                        state_next      = ST_SWEEP;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            timeout_reg    <= TIMEOUT_RESET;
            period_cfg_reg <= PERIOD_RESET;
            slot_valid_reg <= '0;
            now_reg        <= '0;
            period_reg     <= '0;
            armed_reg      <= 1'b0;
            iss_reg        <= '0;
            ev_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            cand_reg       <= '0;
            emit_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            timeout_reg    <= timeout_next;
            period_cfg_reg <= period_cfg_next;
            slot_valid_reg <= slot_valid_next;
            now_reg        <= now_next;
            period_reg     <= period_next;
            armed_reg      <= armed_next;
            iss_reg        <= iss_next;
            ev_vld_reg     <= ev_vld_next;
            hit_found_reg  <= hit_found_next;
            best_found_reg <= best_found_next;
            cand_reg       <= cand_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        req_id_reg      <= req_id_next;
        ev_idx_reg      <= ev_idx_next;
        hit_idx_reg     <= hit_idx_next;
        best_idx_reg    <= best_idx_next;
        best_id_reg     <= best_id_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        pend_last_reg   <= pend_last_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // a live entry always keeps the check timer armed
    `ASSERT_IMPL(a_nonempty_armed, aclk, aresetn, (|slot_valid_reg), armed_reg, "entry held while timer disarmed")
    // a reject is the only result of its put
    `ASSERT_IMPL(a_reject_last, aclk, aresetn, m_tvalid && (m_tuser[0] == STATUS_REJECT), m_tlast, "reject without tlast")
    // one scan never emits more than the result limit
    `ASSERT_IMPL(a_emit_bound, aclk, aresetn, state_reg != ST_IDLE, emit_cnt_reg <= EMIT_W'(MAX_RESULTS), "scan emitted too many results")
    // loading the output never drops a result still waiting
    `ASSERT_NEXT(a_no_overwrite, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "held result lost")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for timeout_table_expiry_core. A predictor of the
// pending-id table scores every result beat against the request stream,
// under random stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    // put/remove sweeps the table once; scan with no expiry does the same
    localparam int SETTLE       = 100;
    localparam int HOLD_CYCLES  = 300;   // long m_tready hold-off
    localparam int STALL_LIMIT  = 3000;  // watchdog: cycles with no beat anywhere
    localparam int POOL_SIZE    = 20;    // small id pool so puts hit, refresh and fill

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] entry_id;
        logic            last;
    } expiry_result_t;

    // ------------------------------------------------------------------------
    // Table predictor plus queue of results still owed by the block.
    // ------------------------------------------------------------------------
    class expiry_tracker;
        logic [CFG_W-1:0]     timeout_ticks;
        logic [CFG_W-1:0]     check_period;
        bit                   slot_used [NUM_ENTRIES];
        logic [ID_W-1:0]      slot_key  [NUM_ENTRIES];
        logic [TIME_BITS-1:0] slot_time [NUM_ENTRIES];
        logic [TIME_BITS-1:0] now_ticks;
        logic [15:0]          period_ticks;
        bit                   armed;
        expiry_result_t       due_results[$];
        int                   errors;
        int                   n_requests;
        int                   n_expired;
        int                   n_rejected;
        int                   n_checked;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            check_period  = PERIOD_RESET;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            now_ticks    = '0;
            period_ticks = '0;
            armed        = 1'b0;
            errors       = 0;
            n_requests   = 0;
            n_expired    = 0;
            n_rejected   = 0;
            n_checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_TIMEOUT) begin
                timeout_ticks = value;
            end else if (idx == REG_PERIOD) begin
                check_period = value;
            end
        endfunction

        function bit table_empty();
            foreach (slot_used[i]) if (slot_used[i]) return 1'b0;
            return 1'b1;
        endfunction

        function void push_due(logic status, logic [ID_W-1:0] id, logic last);
            expiry_result_t r;
            r.status   = status;
            r.entry_id = id;
            r.last     = last;
            due_results.push_back(r);
        endfunction

        // One accepted request beat: update the table, queue what it emits.
        function void apply_request(op_t op, logic [ID_W-1:0] id);
            int                   i;
            int                   k;
            int                   hit;
            int                   free_slot;
            int                   best;
            bit                   picked [NUM_ENTRIES];
            int                   order[$];
            logic [TIME_BITS-1:0] age;
            hit       = -1;
            free_slot = -1;
            n_requests++;
            case (op)
                OP_PUT: begin
                    for (i = 0; i < NUM_ENTRIES; i++) begin
                        if (slot_used[i]) begin
                            if (slot_key[i] == id) hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        slot_time[hit] = now_ticks;       // refresh
                    end else if (free_slot >= 0) begin
                        if (table_empty()) begin
                            armed        = 1'b1;          // (re)start the check timer
                            period_ticks = '0;
                        end
                        slot_used[free_slot] = 1'b1;
                        slot_key[free_slot]  = id;
                        slot_time[free_slot] = now_ticks;
                    end else begin
                        push_due(STATUS_REJECT, id, 1'b1);
                        n_rejected++;
                    end
                end
                OP_REMOVE: begin
                    for (i = 0; i < NUM_ENTRIES; i++)
                        if (slot_used[i] && slot_key[i] == id) slot_used[i] = 1'b0;
                end
                OP_TICK: begin
                    now_ticks = now_ticks + 1'b1;
                    if (armed) begin
                        period_ticks = period_ticks + 1'b1;
                        if (period_ticks >= check_period) begin
                            period_ticks = '0;
                            foreach (picked[j]) picked[j] = 1'b0;
                            // pick aged entries smallest signed id first
                            while (order.size() < MAX_RESULTS) begin
                                best = -1;
                                for (i = 0; i < NUM_ENTRIES; i++) begin
                                    age = now_ticks - slot_time[i];
                                    if (slot_used[i] && !picked[i] && age >= timeout_ticks &&
                                        (best < 0 ||
                                         $signed(slot_key[i]) < $signed(slot_key[best])))
                                        best = i;
                                end
                                if (best < 0) break;
                                picked[best] = 1'b1;
                                order.push_back(best);
                            end
                            for (k = 0; k < order.size(); k++) begin
                                push_due(STATUS_EXPIRED, slot_key[order[k]],
                                         k == order.size() - 1);
                                slot_used[order[k]] = 1'b0;
                            end
                            n_expired += order.size();
                            armed = !table_empty();
                        end
                    end
                end
                default: ;                                // OP_NONE: ignored
            endcase
        endfunction

        // One accepted result beat against the oldest owed result.
        function void check_result(logic status, logic [ID_W-1:0] id, logic last);
            expiry_result_t want;
            n_checked++;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing due: status %0b id %h last %0b",
                         $time, status, id, last);
                return;
            end
            want = due_results.pop_front();
            if (want.status !== status) begin
                errors++;
                $display("%0t: status mismatch, expected %0b actual %0b",
                         $time, want.status, status);
            end
            if (want.entry_id !== id) begin
                errors++;
                $display("%0t: entry_id mismatch, expected %h actual %h",
                         $time, want.entry_id, id);
            end
            if (want.last !== last) begin
                errors++;
                $display("%0t: last mismatch, expected %0b actual %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; all inputs start at known values
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;     // [31:0] id
    logic [1:0]           s_tuser   = '0;     // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;            // [31:0] entry_id
    logic [0:0]           m_tuser;            // [0] status
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    timeout_table_expiry_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    expiry_tracker   board = new();
    logic [ID_W-1:0] id_pool [POOL_SIZE];
    int              send_idle_pct = 0;   // chance per cycle the sender idles
    int              recv_idle_pct = 0;   // chance per cycle m_tready is low
    bit              hold_request  = 1'b0; // asks the receiver for a long hold-off
    int              n_settings    = 0;
    int              quiet_cycles  = 0;

    initial forever #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Result side: score each accepted beat, then pick next m_tready.
    // Values are sampled right after the edge, i.e. as the DUT saw them.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) board.check_result(m_tuser[0], m_tdata, m_tlast);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any beat, register write or reset cycle counts as progress.
    // ------------------------------------------------------------------------
    initial begin
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no beat for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one request beat, with random idle cycles ahead of it. s_tvalid
    // stays high after the handshake so back-to-back beats need no toggle.
    task automatic send_request(input op_t op, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.apply_request(op, id);
    endtask

    // Sender goes quiet until every owed result has been seen.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Drain, then give a scan or sweep that emits nothing time to finish,
    // so the block is idle before registers change.
    task automatic settle();
        drain();
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Both registers back to back, write enable held across both writes.
    task automatic write_settings(input logic [CFG_W-1:0] new_timeout,
                                  input logic [CFG_W-1:0] new_period);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= new_timeout;
        @(posedge aclk);
        cfg_index <= REG_PERIOD;
        cfg_wdata <= new_period;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.write_reg(REG_TIMEOUT, new_timeout);
        board.write_reg(REG_PERIOD, new_period);
        n_settings++;
    endtask

    // Random traffic: mostly puts and ticks over the small id pool so the
    // table fills, refreshes and expires; some removes, stray ids and no-ops.
    task automatic run_random(input int n_items, input int hold_at, input int drain_at);
        op_t             op;
        logic [ID_W-1:0] id;
        int              pick;
        int              k;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 40)      op = OP_PUT;
            else if (pick < 55) op = OP_REMOVE;
            else if (pick < 96) op = OP_TICK;
            else                op = OP_NONE;
            if ($urandom_range(99) < 85) id = id_pool[$urandom_range(POOL_SIZE - 1)];
            else                         id = $urandom;
            if (k == hold_at) hold_request = 1'b1;
            if (k == drain_at) drain();
            send_request(op, id);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int k;
        for (k = 0; k < POOL_SIZE; k++) id_pool[k] = $urandom;
        id_pool[0] = 32'h8000_0000;   // most negative id
        id_pool[1] = 32'h7FFF_FFFF;   // most positive id
        id_pool[2] = 32'h0000_0000;
        id_pool[3] = 32'hFFFF_FFFF;   // -1

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: short timeout, scan on every tick.
        write_settings(16'd2, 16'd1);
        for (k = 0; k < NUM_ENTRIES; k++) send_request(OP_PUT, id_pool[k]); // fill table
        send_request(OP_PUT, id_pool[2]);              // refresh an id while full
        send_request(OP_PUT, id_pool[NUM_ENTRIES]);    // new id while full: reject
        send_request(OP_REMOVE, id_pool[NUM_ENTRIES + 1]); // absent id: ignored
        send_request(OP_NONE, id_pool[1]);             // no-op code
        send_request(OP_TICK, '0);                     // age 1: scan finds nothing
        send_request(OP_TICK, '1);                     // age 2: all 16 expire, signed order
        send_request(OP_PUT, id_pool[5]);              // empty table: arms timer
        send_request(OP_REMOVE, id_pool[5]);           // empty again, timer still armed
        send_request(OP_PUT, id_pool[6]);              // put into empty table restarts timer
        send_request(OP_TICK, '0);

        // Phase 1: sender idles lightly, receiver heavily; long hold-off early.
        settle();
        write_settings(16'd5, 16'd3);
        send_idle_pct = 11;
        recv_idle_pct = 61;
        run_random(70, 10, -1);

        // Phase 2: roles swapped; both registers set to 1; sender drains mid-phase.
        settle();
        write_settings(16'd1, 16'd1);
        send_idle_pct = 61;
        recv_idle_pct = 11;
        run_random(70, -1, 35);

        // Phase 3: no idling, random moderate registers.
        settle();
        write_settings(16'($urandom_range(1, 40)), 16'($urandom_range(1, 12)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(70, -1, -1);

        // Phase 4: maximum registers; nothing expires, table fills up.
        settle();
        write_settings(16'hFFFF, 16'hFFFF);
        run_random(40, -1, -1);

        settle();
        $display("Run: %0d requests over %0d register settings, %0d expiries, %0d rejects.",
                 board.n_requests, n_settings, board.n_expired, board.n_rejected);
        $display("Result beats checked: %0d, mismatches: %0d, still owed: %0d.",
                 board.n_checked, board.errors, board.due_results.size());
        if (board.errors == 0 && board.due_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
